// ===== hdl/measurement_limit_checker_defines.svh =====
// Assertion macros for the measurement limit checker
`ifndef MEASUREMENT_LIMIT_CHECKER_DEFINES_SVH
`define MEASUREMENT_LIMIT_CHECKER_DEFINES_SVH
`ifndef SYNTHESIS
`define MLC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mlc: assertion failed");
`define MLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mlc: assertion failed");
`else
`define MLC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define MLC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/mlc_pkg.sv =====
package mlc_pkg;

  localparam int SAMPLE_BITS_DEF       = 24;
  localparam int FACTOR_FRAC_BITS_DEF  = 16;
  localparam int HYST_FRACTION_Q16_DEF = 655;

  localparam int MS_W       = 47;
  localparam int TRIP_W     = 24;
  localparam int LVL_W      = 23;
  localparam int FACTOR_W   = 16;
  localparam int CFG_DATA_W = 47;
  localparam int CFG_IDX_W  = 4;
  localparam int MUL_W      = 32;
  localparam int HQ_SHIFT   = 16;
  localparam int HQ_W       = HQ_SHIFT + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INVERT_SENSE    = 4'd0,
    REG_POS_TRIP_LEVEL  = 4'd1,
    REG_NEG_TRIP_LEVEL  = 4'd2,
    REG_LOW_LEVEL       = 4'd3,
    REG_ZERO_LEVEL      = 4'd4,
    REG_FILTER_FACTOR   = 4'd5,
    REG_RMS_TRIP_SQUARE = 4'd6,
    REG_RMS_WARN_SQUARE = 4'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                invert_sense;
    logic [TRIP_W-1:0]   pos_trip_level;
    logic [TRIP_W-1:0]   neg_trip_level;
    logic [LVL_W-1:0]    low_level;
    logic [LVL_W-1:0]    zero_level;
    logic [FACTOR_W-1:0] filter_factor;
    logic [MS_W-1:0]     rms_trip_square;
    logic [MS_W-1:0]     rms_warn_square;
    logic [LVL_W-1:0]    low_hyst;
    logic [LVL_W-1:0]    zero_hyst;
    logic [MS_W-1:0]     warn_hyst;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    pos_trip_level: 24'h7F_FFFF,
    default:        '0
  };

  typedef struct packed {
    logic levels;
    logic rms;
  } cfg_clr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_DIFF,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_STEP,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic load;
    logic square;
    logic diff;
    logic mul_lo;
    logic mul_hi;
    logic step;
    logic update;
  } dp_cmd_t;

  typedef struct packed {
    logic out_full;
  } dp_stat_t;

endpackage

// ===== hdl/mlc_if.sv =====
interface mlc_in_if #(
  parameter int SAMPLE_BITS = 24
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mlc_out_if #(
  parameter int MS_W = 47
);
  logic            valid;
  logic            ready;
  logic            trip_flag;
  logic            rms_trip_flag;
  logic            rms_warn_flag;
  logic            zero_flag;
  logic            low_flag;
  logic [MS_W-1:0] mean_square;

  modport source (output valid, output trip_flag, output rms_trip_flag, output rms_warn_flag,
                  output zero_flag, output low_flag, output mean_square, input ready);
  modport sink   (input valid, input trip_flag, input rms_trip_flag, input rms_warn_flag,
                  input zero_flag, input low_flag, input mean_square, output ready);
endinterface

// ===== hdl/measurement_limit_checker.sv =====
// A request is taken only in idle, then runs through the square, difference, gain low, gain
// high, step and update states; the single 32x32 multiplier is used for the square and the
// two halves of the filter gain. No new request is taken until the update state completes.
// A result not taken holds the next request in its update stage until the output drains.
// Reset (rst_n, synchronous, active low): registers to defaults, filter and flags to zero.
module measurement_limit_checker #(
  parameter int SAMPLE_BITS       = mlc_pkg::SAMPLE_BITS_DEF,
  parameter int FACTOR_FRAC_BITS  = mlc_pkg::FACTOR_FRAC_BITS_DEF,
  parameter int HYST_FRACTION_Q16 = mlc_pkg::HYST_FRACTION_Q16_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mlc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlc_pkg::CFG_DATA_W-1:0] cfg_data,
  mlc_in_if.sink                         in_ch,
  mlc_out_if.source                      out_ch
);
  import mlc_pkg::*;

  cfg_t     cfg;
  cfg_clr_t clr;
  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;

  mlc_cfg #(
    .HYST_FRACTION_Q16(HYST_FRACTION_Q16)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg),
    .clr      (clr)
  );

  mlc_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_ch.valid),
    .in_ready(in_ready),
    .stat    (stat),
    .cmd     (cmd)
  );

  mlc_dp #(
    .SAMPLE_BITS     (SAMPLE_BITS),
    .FACTOR_FRAC_BITS(FACTOR_FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_sample(in_ch.sample),
    .cfg      (cfg),
    .clr      (clr),
    .cmd      (cmd),
    .stat     (stat),
    .out_ch   (out_ch)
  );

  assign in_ch.ready = in_ready;

endmodule

// ===== hdl/mlc_cfg.sv =====
module mlc_cfg #(
  parameter int HYST_FRACTION_Q16 = mlc_pkg::HYST_FRACTION_Q16_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [mlc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mlc_pkg::CFG_DATA_W-1:0] cfg_data,
  output mlc_pkg::cfg_t                  cfg,
  output mlc_pkg::cfg_clr_t              clr
);
  import mlc_pkg::*;

  localparam logic [HQ_W-1:0] LVL_MUL  = HQ_W'((1 << HQ_SHIFT) - HYST_FRACTION_Q16);
  localparam logic [HQ_W-1:0] WARN_MUL = HQ_W'((1 << HQ_SHIFT) - 2 * HYST_FRACTION_Q16);

  cfg_t                     cfg_r, cfg_nxt;
  logic [LVL_W+HQ_W-1:0]    zprod, lprod;
  logic [MS_W+HQ_W-1:0]     wprod;

  // hysteresis levels are registered from the level registers and follow them in the next cycle
  always_comb begin
    zprod = {{HQ_W{1'b0}}, cfg_r.zero_level} * {{LVL_W{1'b0}}, LVL_MUL};
    lprod = {{HQ_W{1'b0}}, cfg_r.low_level} * {{LVL_W{1'b0}}, LVL_MUL};
    wprod = {{HQ_W{1'b0}}, cfg_r.rms_warn_square} * {{MS_W{1'b0}}, WARN_MUL};

    cfg_nxt           = cfg_r;
    cfg_nxt.zero_hyst = zprod[HQ_SHIFT +: LVL_W];
    cfg_nxt.low_hyst  = lprod[HQ_SHIFT +: LVL_W];
    cfg_nxt.warn_hyst = wprod[HQ_SHIFT +: MS_W];
    clr               = '0;

    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_INVERT_SENSE: begin
          cfg_nxt.invert_sense = cfg_data[0];
          clr.levels = 1'b1;
        end
        REG_POS_TRIP_LEVEL: begin
          cfg_nxt.pos_trip_level = cfg_data[TRIP_W-1:0];
          clr.levels = 1'b1;
        end
        REG_NEG_TRIP_LEVEL: begin
          cfg_nxt.neg_trip_level = cfg_data[TRIP_W-1:0];
          clr.levels = 1'b1;
        end
        REG_LOW_LEVEL: begin
          cfg_nxt.low_level = cfg_data[LVL_W-1:0];
          clr.levels = 1'b1;
        end
        REG_ZERO_LEVEL: begin
          cfg_nxt.zero_level = cfg_data[LVL_W-1:0];
          clr.levels = 1'b1;
        end
        REG_FILTER_FACTOR: begin
          cfg_nxt.filter_factor = cfg_data[FACTOR_W-1:0];
          clr.rms = 1'b1;
        end
        REG_RMS_TRIP_SQUARE: begin
          cfg_nxt.rms_trip_square = cfg_data[MS_W-1:0];
          clr.rms = 1'b1;
        end
        REG_RMS_WARN_SQUARE: begin
          cfg_nxt.rms_warn_square = cfg_data[MS_W-1:0];
          clr.rms = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/mlc_ctrl.sv =====
module mlc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mlc_pkg::dp_stat_t stat,
  output mlc_pkg::dp_cmd_t  cmd
);
  import mlc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        cmd.mul_lo = 1'b1;
        state_nxt  = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        cmd.mul_hi = 1'b1;
        state_nxt  = ST_STEP;
      end
      ST_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        // wait for the output register to drain
        if (!stat.out_full) begin
          cmd.update = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/mlc_dp.sv =====
`include "measurement_limit_checker_defines.svh"

module mlc_dp #(
  parameter int SAMPLE_BITS      = mlc_pkg::SAMPLE_BITS_DEF,
  parameter int FACTOR_FRAC_BITS = mlc_pkg::FACTOR_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  mlc_pkg::cfg_t                 cfg,
  input  mlc_pkg::cfg_clr_t             clr,
  input  mlc_pkg::dp_cmd_t              cmd,
  output mlc_pkg::dp_stat_t             stat,
  mlc_out_if.source                     out_ch
);
  import mlc_pkg::*;

  localparam int FILT_W = (2 * SAMPLE_BITS - 1 > MS_W) ? 2 * SAMPLE_BITS - 1 : MS_W;
  localparam int HI_W   = FILT_W - MUL_W;
  localparam int PW     = FILT_W + FACTOR_W;
  localparam int TW     = (SAMPLE_BITS > TRIP_W) ? SAMPLE_BITS : TRIP_W;
  localparam int MW     = (SAMPLE_BITS > LVL_W) ? SAMPLE_BITS : LVL_W;

  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMAX = ~SMIN;
  localparam logic [FILT_W-1:0] MAX_SQ = FILT_W'(1) << (2 * SAMPLE_BITS - 2);

  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [SAMPLE_BITS-1:0] m_s;
  logic        [SAMPLE_BITS-1:0] am, mag_c, mag_r;
  logic signed [TW-1:0]          m_x, pos_x, neg_x;
  logic                          trip_c, trip_r;

  logic [MUL_W-1:0]          mul_a, mul_b;
  logic [2*MUL_W-1:0]        mul_p;
  logic [FILT_W-1:0]         sq_r, diff_r, step_r, f_r, f_nxt, f_new;
  logic                      ge_r;
  logic [MUL_W+FACTOR_W-1:0] plo_r;
  logic [HI_W+FACTOR_W-1:0]  phi_r;
  logic [PW-1:0]             sum;
  logic [FILT_W-1:0]         rts, rws, rwh;
  logic [MW-1:0]             mag_x, zl_x, zh_x, ll_x, lh_x;

  logic rtrip_r, rtrip_nxt, rwarn_r, rwarn_nxt;
  logic zero_r, zero_nxt, low_r, low_nxt;
  logic ov_r, ov_nxt;

  // sense inversion, trip test and magnitude
  always_comb begin
    m_s = sample_r;
    if (cfg.invert_sense) begin
      m_s = (sample_r == SMIN) ? SMAX : -sample_r;
    end
    am     = m_s[SAMPLE_BITS-1] ? $unsigned(-m_s) : $unsigned(m_s);
    mag_c  = sample_r[SAMPLE_BITS-1] ? $unsigned(-sample_r) : $unsigned(sample_r);
    m_x    = TW'(m_s);
    pos_x  = TW'($signed(cfg.pos_trip_level));
    neg_x  = TW'($signed(cfg.neg_trip_level));
    trip_c = (m_x > pos_x) || (cfg.neg_trip_level[TRIP_W-1] && (m_x < neg_x));
  end

  // shared multiplier: square, then gain on low and high halves of the difference
  always_comb begin
    if (cmd.mul_lo) begin
      mul_a = diff_r[MUL_W-1:0];
      mul_b = MUL_W'(cfg.filter_factor);
    end else if (cmd.mul_hi) begin
      mul_a = MUL_W'(diff_r[FILT_W-1:MUL_W]);
      mul_b = MUL_W'(cfg.filter_factor);
    end else begin
      mul_a = MUL_W'(am);
      mul_b = MUL_W'(am);
    end
    mul_p = mul_a * mul_b;
    sum   = {phi_r, {MUL_W{1'b0}}} + PW'(plo_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= in_sample;
    end
    if (cmd.square) begin
      sq_r   <= mul_p[FILT_W-1:0];
      trip_r <= trip_c;
      mag_r  <= mag_c;
    end
    if (cmd.diff) begin
      ge_r   <= (sq_r >= f_r);
      diff_r <= (sq_r >= f_r) ? sq_r - f_r : f_r - sq_r;
    end
    if (cmd.mul_lo) begin
      plo_r <= mul_p[MUL_W+FACTOR_W-1:0];
    end
    if (cmd.mul_hi) begin
      phi_r <= mul_p[HI_W+FACTOR_W-1:0];
    end
    if (cmd.step) begin
      step_r <= FILT_W'(sum >> FACTOR_FRAC_BITS);
    end
  end

  // filter update, flag hysteresis, config-write clears and output valid
  always_comb begin
    f_new = ge_r ? f_r + step_r : f_r - step_r;
    rts   = FILT_W'(cfg.rms_trip_square);
    rws   = FILT_W'(cfg.rms_warn_square);
    rwh   = FILT_W'(cfg.warn_hyst);
    mag_x = MW'(mag_r);
    zl_x  = MW'(cfg.zero_level);
    zh_x  = MW'(cfg.zero_hyst);
    ll_x  = MW'(cfg.low_level);
    lh_x  = MW'(cfg.low_hyst);

    f_nxt     = f_r;
    rtrip_nxt = rtrip_r;
    rwarn_nxt = rwarn_r;
    zero_nxt  = zero_r;
    low_nxt   = low_r;

    if (clr.rms) begin
      rtrip_nxt = 1'b0;
      rwarn_nxt = 1'b0;
    end
    if (clr.levels) begin
      zero_nxt = 1'b0;
      low_nxt  = 1'b0;
    end

    if (cmd.update) begin
      if (cfg.filter_factor != '0) begin
        f_nxt     = f_new;
        rtrip_nxt = (rts != '0) && (f_new > rts);
        if (rws != '0) begin
          if (!rwarn_r) begin
            if (f_new > rws) begin
              rwarn_nxt = 1'b1;
            end
          end else if (f_new < rwh) begin
            rwarn_nxt = 1'b0;
          end
        end
      end
      if (zero_r) begin
        if (mag_x > zl_x) begin
          zero_nxt = 1'b0;
        end
      end else if (mag_x < zh_x) begin
        zero_nxt = 1'b1;
      end
      if (low_r) begin
        if (mag_x > ll_x) begin
          low_nxt = 1'b0;
        end
      end else if (mag_x < lh_x) begin
        low_nxt = 1'b1;
      end
    end

    if (cmd.update) begin
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_r     <= '0;
      rtrip_r <= 1'b0;
      rwarn_r <= 1'b0;
      zero_r  <= 1'b0;
      low_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      f_r     <= f_nxt;
      rtrip_r <= rtrip_nxt;
      rwarn_r <= rwarn_nxt;
      zero_r  <= zero_nxt;
      low_r   <= low_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      out_ch.trip_flag     <= trip_r;
      out_ch.rms_trip_flag <= rtrip_nxt;
      out_ch.rms_warn_flag <= rwarn_nxt;
      out_ch.zero_flag     <= zero_nxt;
      out_ch.low_flag      <= low_nxt;
      out_ch.mean_square   <= f_nxt[MS_W-1:0];
    end
  end

  assign out_ch.valid  = ov_r;
  assign stat.out_full = ov_r && !out_ch.ready;

  `MLC_ASSERT_SAME(a_update_slot_free, clk, rst_n, cmd.update, !stat.out_full)
  `MLC_ASSERT_SAME(a_valid_from_update, clk, rst_n, $rose(ov_r), $past(cmd.update))
  `MLC_ASSERT_NEXT(a_filter_held, clk, rst_n, cmd.update && (cfg.filter_factor == '0), $stable(f_r))
  `MLC_ASSERT_SAME(a_filter_bound, clk, rst_n, 1'b1, f_r <= MAX_SQ)

endmodule
